// File: hw/rtl/spq_pkg.sv
// spq_pkg: shared constants, types and status codes of the stable priority queue
// used by spq_cell, spq_out_buf and stable_priority_queue; no dependencies
package spq_pkg;

  localparam int DEPTH    = 64;
  localparam int KEY_BITS = 10;
  localparam int TAG_BITS = 32;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  // one stored entry, moved between neighbor cells
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } spq_entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic       ins;
    logic       pop;
    spq_entry_t data;
  } spq_cmd_t;

  // one result item
  typedef struct packed {
    spq_status_t         status;
    logic [CNT_W-1:0]    position;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    logic [CNT_W-1:0]    length;
  } spq_res_t;

endpackage

// File: hw/rtl/spq_cell.sv
// spq_cell: one slot of the sorted shift chain, holds one key and tag
// depends on spq_pkg
module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_cmd_t  cmd,
  input  logic               occ,
  input  logic               prev_ge,
  input  spq_pkg::spq_entry_t prev_entry,
  input  spq_pkg::spq_entry_t next_entry,
  output spq_pkg::spq_entry_t entry,
  output logic               ge
);
  import spq_pkg::*;

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  // held entry sorts ahead of the incoming key
  assign ge = occ && (entry_r.key >= cmd.data.key);

  // insert keeps, takes the new entry, or shifts down; pop shifts up
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (ge) begin
        entry_nxt = entry_r;
      end else if (prev_ge) begin
        entry_nxt = cmd.data;
      end else begin
        entry_nxt = prev_entry;
      end
    end else if (cmd.pop) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// File: hw/rtl/spq_out_buf.sv
// spq_out_buf: two-deep result buffer, output register plus skid register
// depends on spq_pkg
module spq_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  spq_pkg::spq_res_t res,
  output logic              res_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output spq_pkg::spq_res_t out_res
);
  import spq_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  spq_res_t out_r, out_nxt;
  spq_res_t skid_r, skid_nxt;
  logic     take;
  logic     acc;

  assign res_ready = !skid_valid_r;
  assign take      = out_valid_r && out_ready;
  assign acc       = res_valid && res_ready;

  // next contents of the two slots
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = acc;
        out_nxt       = res;
      end
    end else if (!out_valid_r) begin
      out_valid_nxt = acc;
      out_nxt       = res;
    end else if (acc) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// File: hw/rtl/stable_priority_queue.sv
// stable_priority_queue: bounded priority queue kept as a sorted chain of cells
// depends on spq_pkg, spq_cell, spq_out_buf
//
// Usage:
//   Input channel in_valid/in_ready carries in_mode, in_key, in_tag.
//   in_mode 0 inserts the entry; it goes after every held entry whose key
//   is greater or equal, so equal keys leave in arrival order. in_mode 1
//   pops the head entry.
//   Result channel out_valid/out_ready carries out_status, out_position,
//   out_key, out_tag and out_length, one result item per input item.
//   For each item, every cell compares its key with the new key and keeps,
//   loads or shifts its entry in the same edge that accepts the item. The
//   result is registered in the output register or, while one waits, the
//   skid register; the block takes one item per cycle while results drain.
//   A two-deep result buffer lets one more item in while a result waits;
//   if the receiver stalls longer, in_ready drops until a result is taken.
//   Insert on a full queue returns a full status, pop on an empty queue an
//   empty status; neither changes the stored entries.
//   Reset (rst_n low, synchronous) empties the queue and the result buffer;
//   cell contents are not cleared, occupancy follows from the entry count.
module stable_priority_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [spq_pkg::KEY_BITS-1:0] in_key,
  input  logic [spq_pkg::TAG_BITS-1:0] in_tag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [spq_pkg::CNT_W-1:0]    out_position,
  output logic [spq_pkg::KEY_BITS-1:0] out_key,
  output logic [spq_pkg::TAG_BITS-1:0] out_tag,
  output logic [spq_pkg::CNT_W-1:0]    out_length
);
  import spq_pkg::*;

  logic             [CNT_W-1:0] count_r, count_nxt;
  logic                         acc;
  logic                         full;
  logic                         empty;
  logic                         buf_ready;
  spq_cmd_t                     cmd;
  spq_res_t                     res;
  spq_res_t                     out_res;
  spq_entry_t                   entries [DEPTH];
  logic             [DEPTH-1:0] ge;
  logic             [DEPTH-1:0] prev_ge;
  logic             [DEPTH-1:0] occ;
  logic             [CNT_W-1:0] ins_pos;

  assign in_ready = buf_ready;
  assign acc      = in_valid && buf_ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  // command broadcast to the chain
  always_comb begin
    cmd.ins      = acc && !in_mode && !full;
    cmd.pop      = acc && in_mode && !empty;
    cmd.data.key = in_key;
    cmd.data.tag = in_tag;
  end

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t next_e;
    assign occ[i] = (CNT_W'(i) < count_r);
    if (i == 0) begin : g_head
      assign prev_ge[i] = 1'b1;
    end else begin : g_body
      assign prev_ge[i] = ge[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_e = entries[i];
    end else begin : g_mid
      assign next_e = entries[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ        (occ[i]),
      .prev_ge    (prev_ge[i]),
      .prev_entry ((i == 0) ? cmd.data : entries[(i == 0) ? 0 : i-1]),
      .next_entry (next_e),
      .entry      (entries[i]),
      .ge         (ge[i])
    );
  end

  // insert slot from the one-hot boundary of the greater-or-equal prefix
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (prev_ge[i] && !ge[i]) begin
        ins_pos = ins_pos | CNT_W'(i + 1);
      end
    end
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result item
  always_comb begin
    res.status   = ST_OK;
    res.position = '0;
    res.key      = '0;
    res.tag      = '0;
    res.length   = count_nxt;
    if (!in_mode) begin
      if (full) begin
        res.status = ST_FULL;
      end else begin
        res.position = ins_pos;
      end
    end else begin
      if (empty) begin
        res.status = ST_EMPTY;
      end else begin
        res.key = entries[0].key;
        res.tag = entries[0].tag;
      end
    end
  end

  spq_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (in_valid),
    .res       (res),
    .res_ready (buf_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status   = out_res.status;
  assign out_position = out_res.position;
  assign out_key      = out_res.key;
  assign out_tag      = out_res.tag;
  assign out_length   = out_res.length;

endmodule
